/* rtl/hfpd_pkg.sv */
// Shared types and constants for the header-framed pair deframer.
// Used by hfpd_parser and header_framed_pair_deframer. No dependencies.
`timescale 1ns / 1ps

package hfpd_pkg;

  // Frame layout: two header bytes, then a fixed payload of two 32-bit words.
  localparam int PAYLOAD_LEN = 8;
  localparam int CNT_W       = $clog2(PAYLOAD_LEN);
  localparam int STORE_W     = 8 * (PAYLOAD_LEN - 1);

  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(PAYLOAD_LEN - 1);

  // Configuration register indexes.
  localparam logic [1:0] REG_HEADER_FIRST  = 2'd0;
  localparam logic [1:0] REG_HEADER_SECOND = 2'd1;
  localparam logic [1:0] REG_ACCEPT_LIMIT  = 2'd2;

  localparam logic [30:0] ACCEPT_LIMIT_RESET = 31'd90;

  // Parser phases.
  typedef enum logic [1:0] {
    PHASE_IDLE = 2'd0,
    PHASE_HDR1 = 2'd1,
    PHASE_DATA = 2'd2
  } phase_t;

  // What the parser reports for the byte at its input.
  typedef struct packed {
    logic               done;
    logic signed [31:0] angle;
    logic signed [31:0] offset;
  } frame_t;

endpackage

/* rtl/hfpd_parser.sv */
// Frame parser: header match state machine and payload byte collector.
// Depends on hfpd_pkg.
`timescale 1ns / 1ps

module hfpd_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             beat,
  input  logic [7:0]       rx_byte,
  input  logic [7:0]       header_first,
  input  logic [7:0]       header_second,
  output hfpd_pkg::frame_t frame
);

  hfpd_pkg::phase_t               phase;
  hfpd_pkg::phase_t               phase_next;
  logic [hfpd_pkg::CNT_W-1:0]     count;
  logic [hfpd_pkg::CNT_W-1:0]     count_next;
  logic [hfpd_pkg::STORE_W-1:0]   payload;
  logic                           shift_in;
  logic [hfpd_pkg::STORE_W+7:0]   all_bytes;

  // Next phase and payload count for the byte at the input.
  always_comb begin
    phase_next = phase;
    count_next = count;
    shift_in   = 1'b0;
    unique case (phase)
      hfpd_pkg::PHASE_IDLE: begin
        if (rx_byte == header_first) begin
          phase_next = hfpd_pkg::PHASE_HDR1;
        end
      end
      hfpd_pkg::PHASE_HDR1: begin
        // A wrong second header drops back to idle without a retest.
        if (rx_byte == header_second) begin
          phase_next = hfpd_pkg::PHASE_DATA;
          count_next = '0;
        end else begin
          phase_next = hfpd_pkg::PHASE_IDLE;
        end
      end
      hfpd_pkg::PHASE_DATA: begin
        if (count == hfpd_pkg::LAST_CNT) begin
          phase_next = hfpd_pkg::PHASE_IDLE;
          count_next = '0;
        end else begin
          shift_in   = 1'b1;
          count_next = count + 1'b1;
        end
      end
      default: begin
        phase_next = hfpd_pkg::PHASE_IDLE;
      end
    endcase
  end

  // The last payload byte completes the frame; earlier bytes sit in the store,
  // shifted down so that the first byte ends up in the low bits.
  assign all_bytes = {rx_byte, payload};

  always_comb begin
    frame.done   = (phase == hfpd_pkg::PHASE_DATA) && (count == hfpd_pkg::LAST_CNT);
    frame.angle  = $signed(all_bytes[31:0]);
    frame.offset = $signed(all_bytes[63:32]);
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= hfpd_pkg::PHASE_IDLE;
      count <= '0;
    end else if (beat) begin
      phase <= phase_next;
      count <= count_next;
    end
  end

  // Payload store.
  always_ff @(posedge clk) begin
    if (beat && shift_in) begin
      payload <= {rx_byte, payload[hfpd_pkg::STORE_W-1:8]};
    end
  end

endmodule

/* rtl/hfpd_filter.sv */
// Range filter for the angle and offset words, with last-accepted hold registers.
// Does not use hfpd_pkg; standalone logic.
`timescale 1ns / 1ps

module hfpd_filter (
  input  logic               clk,
  input  logic               rst,
  input  logic               commit,
  input  logic [30:0]        accept_limit,
  input  logic signed [31:0] angle_raw,
  input  logic signed [31:0] offset_raw,
  output logic signed [31:0] angle_out,
  output logic signed [31:0] offset_out,
  output logic               angle_held,
  output logic               offset_held
);

  logic signed [31:0] last_angle;
  logic signed [31:0] last_offset;
  logic signed [32:0] pos_lim;
  logic signed [32:0] neg_lim;
  logic signed [32:0] angle_ext;
  logic signed [32:0] offset_ext;
  logic               angle_pass;
  logic               offset_pass;

  // Strict window test in 33 bits so every limit and every value is exact.
  always_comb begin
    pos_lim     = $signed({2'b00, accept_limit});
    neg_lim     = -pos_lim;
    angle_ext   = $signed({angle_raw[31], angle_raw});
    offset_ext  = $signed({offset_raw[31], offset_raw});
    angle_pass  = (angle_ext < pos_lim) && (angle_ext > neg_lim);
    offset_pass = (offset_ext < pos_lim) && (offset_ext > neg_lim);
  end

  // A failing value is replaced by the last one that passed.
  always_comb begin
    angle_out   = angle_pass ? angle_raw : last_angle;
    offset_out  = offset_pass ? offset_raw : last_offset;
    angle_held  = !angle_pass;
    offset_held = !offset_pass;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_angle  <= '0;
      last_offset <= '0;
    end else if (commit) begin
      if (angle_pass) begin
        last_angle <= angle_raw;
      end
      if (offset_pass) begin
        last_offset <= offset_raw;
      end
    end
  end

endmodule

/* rtl/header_framed_pair_deframer.sv */
// Header-framed pair deframer, one result per frame; uses hfpd_pkg, hfpd_parser, hfpd_filter.
// A frame's last byte shows as a result in the cycle after its beat is taken.
// Throughput: one byte per cycle; the input register drains while a result waits.
// Only the final payload byte of a frame needs the result register to be free.
// Reset (rst, synchronous) returns the parser to idle, clears the held values to zero
// and loads the register defaults: both headers 0, limit 90.
`timescale 1ns / 1ps

module header_framed_pair_deframer (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               rx_valid,
  output logic               rx_ready,
  input  logic [7:0]         rx_byte,
  output logic               res_valid,
  input  logic               res_ready,
  output logic signed [31:0] angle_raw,
  output logic signed [31:0] offset_raw,
  output logic signed [31:0] angle_out,
  output logic signed [31:0] offset_out,
  output logic               angle_held,
  output logic               offset_held
);

  logic [7:0]         header_first;
  logic [7:0]         header_second;
  logic [30:0]        accept_limit;
  logic               s1_valid;
  logic [7:0]         s1_byte;
  logic               out_free;
  logic               s1_advance;
  logic               commit;
  hfpd_pkg::frame_t   frame;
  logic signed [31:0] flt_angle;
  logic signed [31:0] flt_offset;
  logic               flt_angle_held;
  logic               flt_offset_held;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_first  <= '0;
      header_second <= '0;
      accept_limit  <= hfpd_pkg::ACCEPT_LIMIT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        hfpd_pkg::REG_HEADER_FIRST:  header_first  <= cfg_data[7:0];
        hfpd_pkg::REG_HEADER_SECOND: header_second <= cfg_data[7:0];
        hfpd_pkg::REG_ACCEPT_LIMIT:  accept_limit  <= cfg_data[30:0];
        default: begin
        end
      endcase
    end
  end

  // Handshake: a byte leaves the input register unless it completes a frame
  // while the result register is still occupied.
  assign out_free   = !res_valid || res_ready;
  assign s1_advance = s1_valid && (!frame.done || out_free);
  assign commit     = s1_advance && frame.done;
  assign rx_ready   = !s1_valid || s1_advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx_ready) begin
      s1_valid <= rx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_valid && rx_ready) begin
      s1_byte <= rx_byte;
    end
  end

  hfpd_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .beat          (s1_advance),
    .rx_byte       (s1_byte),
    .header_first  (header_first),
    .header_second (header_second),
    .frame         (frame)
  );

  hfpd_filter u_filter (
    .clk          (clk),
    .rst          (rst),
    .commit       (commit),
    .accept_limit (accept_limit),
    .angle_raw    (frame.angle),
    .offset_raw   (frame.offset),
    .angle_out    (flt_angle),
    .offset_out   (flt_offset),
    .angle_held   (flt_angle_held),
    .offset_held  (flt_offset_held)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (commit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      angle_raw   <= frame.angle;
      offset_raw  <= frame.offset;
      angle_out   <= flt_angle;
      offset_out  <= flt_offset;
      angle_held  <= flt_angle_held;
      offset_held <= flt_offset_held;
    end
  end

`ifndef ASSERT_OFF
  // A result only appears the cycle after a completed frame is committed.
  assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(commit))
    else $error("result valid rose without a committed frame");

  // A frame is never committed over a result that has not been taken.
  assert property (@(posedge clk) disable iff (rst)
    commit |-> (!res_valid || res_ready))
    else $error("commit overwrote a pending result");

  // A new byte is only taken when the input register empties or moves on.
  assert property (@(posedge clk) disable iff (rst)
    (rx_valid && rx_ready) |-> (!s1_valid || s1_advance))
    else $error("input register overrun");

  // An unheld value must equal its raw value.
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && !angle_held) |-> (angle_out == angle_raw))
    else $error("angle passed but differs from raw");

  assert property (@(posedge clk) disable iff (rst)
    (res_valid && !offset_held) |-> (offset_out == offset_raw))
    else $error("offset passed but differs from raw");
`endif

endmodule
